/* src/rmth_pkg.sv */
// shared constants, types and helpers for the running median block
`timescale 1ns / 1ps
`default_nettype none
package rmth_pkg;

    localparam int HEAP_DEPTH = 512;
    localparam int SLOTS      = HEAP_DEPTH + 1;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int TOT_W      = $clog2(2 * HEAP_DEPTH + 1);
    localparam int DATA_W     = 32;
    localparam int MED_W      = DATA_W + 1;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        HEAP_NOP,
        HEAP_INSERT,
        HEAP_REMOVE
    } heap_op_t;

    typedef struct packed {
        logic                      start;
        heap_op_t                  op;
        logic signed [DATA_W-1:0]  val;
    } heap_cmd_t;

    typedef struct packed {
        logic                      busy;
        logic        [CNT_W-1:0]   count;
        logic signed [DATA_W-1:0]  top;
    } heap_stat_t;

    typedef enum logic [2:0] {
        H_IDLE,
        H_UP_CMP,
        H_UP_FIN,
        H_DN_LOAD,
        H_DN_CMP
    } heap_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_GROW,
        B_MOVE,
        B_PLACE,
        B_EMIT
    } back_state_t;

    // a belongs above b: greater for a max-heap, smaller for a min-heap
    function automatic logic ranks_above(logic signed [DATA_W-1:0] a,
                                         logic signed [DATA_W-1:0] b,
                                         logic is_max);
        ranks_above = is_max ? (a > b) : (a < b);
    endfunction

endpackage
`default_nettype wire

/* src/rmth_front.sv */
// input word queue between the push side and the heap sequencer
`timescale 1ns / 1ps
`default_nettype none
module rmth_front (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push,
    input  wire logic signed [rmth_pkg::DATA_W-1:0] sample,
    output logic                                    full,
    output logic                                    out_valid,
    output logic signed [rmth_pkg::DATA_W-1:0]      out_sample,
    input  wire logic                               take
);

    logic signed [rmth_pkg::DATA_W-1:0] buf_reg [rmth_pkg::FIFO_DEPTH];
    logic [rmth_pkg::FIFO_AW-1:0] wptr_reg, wptr_next;
    logic [rmth_pkg::FIFO_AW-1:0] rptr_reg, rptr_next;
    logic [rmth_pkg::FIFO_AW:0]   fill_reg, fill_next;
    logic                         do_push;
    logic                         do_take;

    assign full       = (fill_reg == (rmth_pkg::FIFO_AW+1)'(rmth_pkg::FIFO_DEPTH));
    assign out_valid  = (fill_reg != '0);
    assign out_sample = buf_reg[rptr_reg];
    assign do_push    = push && !full;
    assign do_take    = take && out_valid;

    always_comb
    begin
        wptr_next = do_push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = do_take ? rptr_reg + 1'b1 : rptr_reg;
        fill_next = fill_reg;
        if (do_push && !do_take)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!do_push && do_take)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            buf_reg[wptr_reg] <= sample;
        end
    end

endmodule
`default_nettype wire

/* src/rmth_heap.sv */
// one binary heap in a memory with a sift-up and sift-down sequencer
`timescale 1ns / 1ps
`default_nettype none
module rmth_heap (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 max_mode,
    input  wire rmth_pkg::heap_cmd_t  cmd,
    output rmth_pkg::heap_stat_t      stat
);

    localparam int IW = rmth_pkg::IDX_W;
    localparam int CW = rmth_pkg::CNT_W;
    localparam int DW = rmth_pkg::DATA_W;

    rmth_pkg::heap_state_t state_reg, state_next;
    logic        [IW-1:0] idx_reg, idx_next;
    logic signed [DW-1:0] val_reg, val_next;
    logic        [CW-1:0] cnt_reg, cnt_next;
    logic        [CW-1:0] lim_reg, lim_next;
    logic signed [DW-1:0] top_reg, top_next;

    logic signed [DW-1:0] mem [rmth_pkg::SLOTS];
    logic                 we;
    logic        [IW-1:0] waddr;
    logic signed [DW-1:0] wdata;
    logic        [IW-1:0] raddr_a, raddr_b;
    logic signed [DW-1:0] rdata_a, rdata_b;

    logic        [IW-1:0] par;
    logic        [IW-1:0] par_of_par;
    logic        [IW-1:0] par_of_cnt;
    logic                 go_up;
    logic        [IW:0]   left_w, right_w;
    logic                 l_win, r_win, move;
    logic signed [DW-1:0] cand;
    logic        [IW-1:0] best_idx;
    logic signed [DW-1:0] best_val;
    logic        [IW:0]   best_left, best_right;
    logic                 is_insert, is_remove;

    assign is_insert = cmd.start && (cmd.op == rmth_pkg::HEAP_INSERT);
    assign is_remove = cmd.start && (cmd.op == rmth_pkg::HEAP_REMOVE);

    always_comb
    begin
        par        = (idx_reg - 1'b1) >> 1;
        par_of_par = (par - 1'b1) >> 1;
        par_of_cnt = (cnt_reg[IW-1:0] - 1'b1) >> 1;
        go_up      = rmth_pkg::ranks_above(val_reg, rdata_a, max_mode);
        left_w     = {idx_reg, 1'b0} + (IW+1)'(1);
        right_w    = left_w + (IW+1)'(1);
        l_win      = ((IW+1)'(lim_reg) > left_w)
                     && rmth_pkg::ranks_above(rdata_a, val_reg, max_mode);
        cand       = l_win ? rdata_a : val_reg;
        r_win      = ((IW+1)'(lim_reg) > right_w)
                     && rmth_pkg::ranks_above(rdata_b, cand, max_mode);
        move       = l_win || r_win;
        best_idx   = r_win ? right_w[IW-1:0] : left_w[IW-1:0];
        best_val   = r_win ? rdata_b : rdata_a;
        best_left  = {best_idx, 1'b0} + (IW+1)'(1);
        best_right = best_left + (IW+1)'(1);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rmth_pkg::H_IDLE:
            begin
                if (is_insert && (cnt_reg != '0))
                begin
                    state_next = rmth_pkg::H_UP_CMP;
                end
                else if (is_remove && (cnt_reg > CW'(1)))
                begin
                    state_next = rmth_pkg::H_DN_LOAD;
                end
            end
            rmth_pkg::H_UP_CMP:
            begin
                if (!go_up)
                begin
                    state_next = rmth_pkg::H_IDLE;
                end
                else if (par == '0)
                begin
                    state_next = rmth_pkg::H_UP_FIN;
                end
            end
            rmth_pkg::H_UP_FIN:  state_next = rmth_pkg::H_IDLE;
            rmth_pkg::H_DN_LOAD: state_next = rmth_pkg::H_DN_CMP;
            rmth_pkg::H_DN_CMP:
            begin
                if (!move)
                begin
                    state_next = rmth_pkg::H_IDLE;
                end
            end
            default: state_next = rmth_pkg::H_IDLE;
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        val_next = val_reg;
        cnt_next = cnt_reg;
        lim_next = lim_reg;
        we       = 1'b0;
        waddr    = idx_reg;
        wdata    = val_reg;
        raddr_a  = par_of_par;
        raddr_b  = '0;
        case (state_reg)
            rmth_pkg::H_IDLE:
            begin
                if (is_insert)
                begin
                    val_next = cmd.val;
                    idx_next = cnt_reg[IW-1:0];
                    cnt_next = cnt_reg + 1'b1;
                    raddr_a  = par_of_cnt;
                    if (cnt_reg == '0)
                    begin
                        we    = 1'b1;
                        waddr = '0;
                        wdata = cmd.val;
                    end
                end
                else if (is_remove && (cnt_reg != '0))
                begin
                    cnt_next = cnt_reg - 1'b1;
                    lim_next = cnt_reg - 1'b1;
                    raddr_a  = IW'(cnt_reg - 1'b1);
                end
            end
            rmth_pkg::H_UP_CMP:
            begin
                we = 1'b1;
                if (go_up)
                begin
                    wdata    = rdata_a;
                    idx_next = par;
                end
            end
            rmth_pkg::H_UP_FIN:
            begin
                we    = 1'b1;
                waddr = '0;
            end
            rmth_pkg::H_DN_LOAD:
            begin
                val_next = rdata_a;
                idx_next = '0;
                raddr_a  = IW'(1);
                raddr_b  = IW'(2);
            end
            rmth_pkg::H_DN_CMP:
            begin
                we = 1'b1;
                if (move)
                begin
                    wdata    = best_val;
                    idx_next = best_idx;
                    raddr_a  = best_left[IW-1:0];
                    raddr_b  = best_right[IW-1:0];
                end
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
        top_next = (we && (waddr == '0)) ? wdata : top_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rmth_pkg::H_IDLE;
            cnt_reg   <= '0;
            lim_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            lim_reg   <= lim_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        val_reg <= val_next;
        top_reg <= top_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

    assign stat.busy  = (state_reg != rmth_pkg::H_IDLE);
    assign stat.count = cnt_reg;
    assign stat.top   = top_reg;

endmodule
`default_nettype wire

/* src/rmth_back.sv */
// sequencer that files each sample, rebalances the heaps and holds the result word
`timescale 1ns / 1ps
`default_nettype none
module rmth_back (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire logic signed [rmth_pkg::DATA_W-1:0] in_sample,
    output logic                                    in_take,
    output rmth_pkg::heap_cmd_t                     lo_cmd,
    input  wire rmth_pkg::heap_stat_t               lo_stat,
    output rmth_pkg::heap_cmd_t                     up_cmd,
    input  wire rmth_pkg::heap_stat_t               up_stat,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic signed [rmth_pkg::MED_W-1:0]       median_times_two,
    output logic        [rmth_pkg::TOT_W-1:0]       sample_count,
    output logic                                    dropped
);

    localparam int CW = rmth_pkg::CNT_W;
    localparam int DW = rmth_pkg::DATA_W;
    localparam int MW = rmth_pkg::MED_W;
    localparam int TW = rmth_pkg::TOT_W;

    rmth_pkg::back_state_t state_reg, state_next;
    logic signed [DW-1:0] mv_reg, mv_next;
    logic                 to_up_reg, to_up_next;
    logic                 drop_reg, drop_next;
    logic                 ovalid_reg, ovalid_next;
    logic signed [MW-1:0] omed_reg, omed_next;
    logic        [TW-1:0] ocnt_reg, ocnt_next;
    logic                 odrop_reg, odrop_next;

    logic        [CW:0]   lc, uc;
    logic        [TW-1:0] total;
    logic                 idle_heaps;
    logic                 is_full;
    logic                 lo_heavy, up_heavy;
    logic signed [MW-1:0] med;
    logic                 load;

    always_comb
    begin
        lc         = (CW+1)'(lo_stat.count);
        uc         = (CW+1)'(up_stat.count);
        total      = TW'(lc) + TW'(uc);
        idle_heaps = !lo_stat.busy && !up_stat.busy;
        is_full    = (total >= TW'(2 * rmth_pkg::HEAP_DEPTH));
        lo_heavy   = lc > (uc + 1'b1);
        up_heavy   = uc > (lc + 1'b1);
        if (lc > uc)
        begin
            med = {lo_stat.top, 1'b0};
        end
        else if (uc > lc)
        begin
            med = {up_stat.top, 1'b0};
        end
        else if (lc != '0)
        begin
            med = MW'(lo_stat.top) + MW'(up_stat.top);
        end
        else
        begin
            med = '0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rmth_pkg::B_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = is_full ? rmth_pkg::B_EMIT : rmth_pkg::B_GROW;
                end
            end
            rmth_pkg::B_GROW:
            begin
                if (idle_heaps)
                begin
                    state_next = (lo_heavy || up_heavy) ? rmth_pkg::B_MOVE
                                                        : rmth_pkg::B_EMIT;
                end
            end
            rmth_pkg::B_MOVE:
            begin
                if (idle_heaps)
                begin
                    state_next = rmth_pkg::B_PLACE;
                end
            end
            rmth_pkg::B_PLACE:
            begin
                if (idle_heaps)
                begin
                    state_next = rmth_pkg::B_EMIT;
                end
            end
            rmth_pkg::B_EMIT:
            begin
                if (!ovalid_reg || pop)
                begin
                    state_next = rmth_pkg::B_IDLE;
                end
            end
            default: state_next = rmth_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        in_take    = 1'b0;
        lo_cmd     = '{start: 1'b0, op: rmth_pkg::HEAP_NOP, val: in_sample};
        up_cmd     = '{start: 1'b0, op: rmth_pkg::HEAP_NOP, val: in_sample};
        mv_next    = mv_reg;
        to_up_next = to_up_reg;
        drop_next  = drop_reg;
        load       = 1'b0;
        case (state_reg)
            rmth_pkg::B_IDLE:
            begin
                if (in_valid)
                begin
                    in_take   = 1'b1;
                    drop_next = is_full;
                    if (!is_full)
                    begin
                        if ((lc == '0) || (in_sample < lo_stat.top))
                        begin
                            lo_cmd.start = 1'b1;
                            lo_cmd.op    = rmth_pkg::HEAP_INSERT;
                        end
                        else
                        begin
                            up_cmd.start = 1'b1;
                            up_cmd.op    = rmth_pkg::HEAP_INSERT;
                        end
                    end
                end
            end
            rmth_pkg::B_GROW:
            begin
                if (idle_heaps && lo_heavy)
                begin
                    lo_cmd.start = 1'b1;
                    lo_cmd.op    = rmth_pkg::HEAP_REMOVE;
                    mv_next      = lo_stat.top;
                    to_up_next   = 1'b1;
                end
                else if (idle_heaps && up_heavy)
                begin
                    up_cmd.start = 1'b1;
                    up_cmd.op    = rmth_pkg::HEAP_REMOVE;
                    mv_next      = up_stat.top;
                    to_up_next   = 1'b0;
                end
            end
            rmth_pkg::B_MOVE:
            begin
                if (idle_heaps)
                begin
                    lo_cmd.val = mv_reg;
                    up_cmd.val = mv_reg;
                    if (to_up_reg)
                    begin
                        up_cmd.start = 1'b1;
                        up_cmd.op    = rmth_pkg::HEAP_INSERT;
                    end
                    else
                    begin
                        lo_cmd.start = 1'b1;
                        lo_cmd.op    = rmth_pkg::HEAP_INSERT;
                    end
                end
            end
            rmth_pkg::B_EMIT:
            begin
                load = !ovalid_reg || pop;
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
        ovalid_next = load ? 1'b1 : (pop ? 1'b0 : ovalid_reg);
        omed_next   = load ? med : omed_reg;
        ocnt_next   = load ? total : ocnt_reg;
        odrop_next  = load ? drop_reg : odrop_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rmth_pkg::B_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mv_reg    <= mv_next;
        to_up_reg <= to_up_next;
        drop_reg  <= drop_next;
        omed_reg  <= omed_next;
        ocnt_reg  <= ocnt_next;
        odrop_reg <= odrop_next;
    end

    assign empty            = !ovalid_reg;
    assign median_times_two = omed_reg;
    assign sample_count     = ocnt_reg;
    assign dropped          = odrop_reg;

endmodule
`default_nettype wire

/* src/running_median_two_heaps.sv */
// top level of the running median block built from two heaps
// Each sample word is queued on entry (four deep) and then filed into a max-heap of the
// lower half or a min-heap of the upper half, each held in its own memory with one write
// port. A sift walks one heap level per clock; a word is done soonest when it lands
// near a leaf and takes longest, at 512 entries a heap, when it climbs to the root
// and forces a top to move across (remove, sift-down, insert). The result word gives
// twice the median, the number of samples held, and a drop flag set when 1024 samples
// are already held; it waits in an output register while the next word is taken.
`timescale 1ns / 1ps
`default_nettype none
module running_median_two_heaps (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic signed [rmth_pkg::DATA_W-1:0] sample,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic signed [rmth_pkg::MED_W-1:0]       median_times_two,
    output logic        [rmth_pkg::TOT_W-1:0]       sample_count,
    output logic                                    dropped
);

    logic                               q_valid;
    logic signed [rmth_pkg::DATA_W-1:0] q_sample;
    logic                               q_take;
    rmth_pkg::heap_cmd_t                lo_cmd, up_cmd;
    rmth_pkg::heap_stat_t               lo_stat, up_stat;

    rmth_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .sample     (sample),
        .full       (full),
        .out_valid  (q_valid),
        .out_sample (q_sample),
        .take       (q_take)
    );

    rmth_heap u_lower (
        .clk      (clk),
        .rst_n    (rst_n),
        .max_mode (1'b1),
        .cmd      (lo_cmd),
        .stat     (lo_stat)
    );

    rmth_heap u_upper (
        .clk      (clk),
        .rst_n    (rst_n),
        .max_mode (1'b0),
        .cmd      (up_cmd),
        .stat     (up_stat)
    );

    rmth_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (q_valid),
        .in_sample        (q_sample),
        .in_take          (q_take),
        .lo_cmd           (lo_cmd),
        .lo_stat          (lo_stat),
        .up_cmd           (up_cmd),
        .up_stat          (up_stat),
        .empty            (empty),
        .pop              (pop),
        .median_times_two (median_times_two),
        .sample_count     (sample_count),
        .dropped          (dropped)
    );

endmodule
`default_nettype wire

/* src/rmth_checker.sv */
// port-level checks for the running median block and their bind
`timescale 1ns / 1ps
`default_nettype none
module rmth_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               empty,
    input wire logic                               pop,
    input wire logic signed [rmth_pkg::MED_W-1:0]  median_times_two,
    input wire logic        [rmth_pkg::TOT_W-1:0]  sample_count,
    input wire logic                               dropped
);

    // count never exceeds storage
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (sample_count <= rmth_pkg::TOT_W'(2 * rmth_pkg::HEAP_DEPTH)))
        else $error("sample count beyond storage");

    // a drop only happens with storage full
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && dropped)
        |-> (sample_count == rmth_pkg::TOT_W'(2 * rmth_pkg::HEAP_DEPTH)))
        else $error("drop with free storage");

    // odd count means a single middle sample, so twice it is even
    a_odd_even: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && sample_count[0]) |-> !median_times_two[0])
        else $error("odd median for odd count");

    // a waiting word holds until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(median_times_two)
                              && $stable(sample_count) && $stable(dropped)))
        else $error("result word changed while waiting");

endmodule

bind running_median_two_heaps rmth_checker u_rmth_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .empty            (empty),
    .pop              (pop),
    .median_times_two (median_times_two),
    .sample_count     (sample_count),
    .dropped          (dropped)
);
`default_nettype wire

/* tb/sv/running_median_two_heaps_tb.sv */
// testbench for the running median block: directed table, random streams, heap predictor
`timescale 1ns / 1ps
`default_nettype none
module running_median_two_heaps_tb;

    localparam int LIMIT = 20000;

    typedef struct {
        logic signed [rmth_pkg::MED_W-1:0] med2;
        logic [rmth_pkg::TOT_W-1:0]        count;
        logic                              drop;
    } median_word_t;

    typedef struct {
        logic signed [rmth_pkg::DATA_W-1:0] val;
        logic                               chk;
        logic signed [rmth_pkg::MED_W-1:0]  med2;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic signed [rmth_pkg::DATA_W-1:0] sample = '0;
    logic full, empty, dropped;
    logic signed [rmth_pkg::MED_W-1:0] median_times_two;
    logic [rmth_pkg::TOT_W-1:0] sample_count;

    running_median_two_heaps dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .sample(sample),
        .empty(empty), .pop(pop), .median_times_two(median_times_two),
        .sample_count(sample_count), .dropped(dropped)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    longint lo_heap[$];
    longint hi_heap[$];
    median_word_t pending_medians[$];
    int errors = 0;
    int idle_cycles = 0;
    bit stim_done = 0;

    // sorted queues stand in for the heaps: lo ascending (top at end), hi ascending (top at 0)
    function automatic void sorted_add(ref longint q[$], input longint v);
        int i;
        i = 0;
        while (i < q.size() && q[i] <= v)
            i++;
        q.insert(i, v);
    endfunction

    function automatic median_word_t file_sample(logic signed [rmth_pkg::DATA_W-1:0] s);
        median_word_t w;
        longint v;
        v = s;
        w.drop = 1'b0;
        if (lo_heap.size() + hi_heap.size() >= 2 * rmth_pkg::HEAP_DEPTH)
            w.drop = 1'b1;
        else
        begin
            if (lo_heap.size() == 0 || v < lo_heap[$])
                sorted_add(lo_heap, v);
            else
                sorted_add(hi_heap, v);
            if (lo_heap.size() > hi_heap.size() + 1)
                sorted_add(hi_heap, lo_heap.pop_back());
            else if (hi_heap.size() > lo_heap.size() + 1)
                sorted_add(lo_heap, hi_heap.pop_front());
        end
        if (lo_heap.size() > hi_heap.size())
            w.med2 = rmth_pkg::MED_W'(2 * lo_heap[$]);
        else if (hi_heap.size() > lo_heap.size())
            w.med2 = rmth_pkg::MED_W'(2 * hi_heap[0]);
        else if (lo_heap.size() > 0)
            w.med2 = rmth_pkg::MED_W'(lo_heap[$] + hi_heap[0]);
        else
            w.med2 = '0;
        w.count = rmth_pkg::TOT_W'(lo_heap.size() + hi_heap.size());
        return w;
    endfunction

    task automatic send_sample(logic signed [rmth_pkg::DATA_W-1:0] s, bit chk,
                               logic signed [rmth_pkg::MED_W-1:0] med2);
        median_word_t w;
        int n;
        n = $urandom_range(0, 16) * ($urandom_range(0, 3) != 0);
        if (n != 0)
        begin
            push <= 1'b0;
            repeat (n) @(negedge clk);
        end
        push <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (full)
            @(posedge clk);
        w = file_sample(s);
        if (chk && w.med2 !== med2)
        begin
            $error("table row median: expected %0d, predictor %0d", med2, w.med2);
            errors++;
        end
        pending_medians.push_back(w);
        @(negedge clk);
    endtask

    function automatic logic signed [rmth_pkg::DATA_W-1:0] rand_sample(int mode);
        case (mode)
            0: return $urandom();
            1: return $signed($urandom_range(0, 40)) - 20;
            2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(0, 2000000)) - 1000000;
        endcase
    endfunction

    stim_row_t rows[] = '{
        '{32'sh7fffffff, 1'b1, 33'sh0fffffffe},
        '{32'sh7fffffff, 1'b1, 33'sh0fffffffe},
        '{32'sh80000000, 1'b1, 33'sh0fffffffe},
        '{32'sh80000000, 1'b0, '0},
        '{32'sh80000000, 1'b0, '0},
        '{32'sh80000000, 1'b0, '0},
        '{0, 1'b0, '0},
        '{-1, 1'b0, '0},
        '{1, 1'b0, '0},
        '{5, 1'b0, '0},
        '{5, 1'b0, '0},
        '{32'sh55555555, 1'b0, '0},
        '{32'shaaaaaaaa, 1'b0, '0}
    };

    initial
    begin
        int mode;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        foreach (rows[i])
            send_sample(rows[i].val, rows[i].chk, rows[i].med2);
        // fill storage to the brim, then keep pushing to see drops
        while (lo_heap.size() + hi_heap.size() < 2 * rmth_pkg::HEAP_DEPTH)
            send_sample(rand_sample($urandom_range(0, 3)), 1'b0, '0);
        repeat (30)
            send_sample(rand_sample($urandom_range(0, 3)), 1'b0, '0);
        push <= 1'b0;
        @(negedge clk);
        while (pending_medians.size() != 0)
            @(negedge clk);
        for (int k = 0; k < 700; k++)
        begin
            mode = $urandom_range(0, 3);
            send_sample(rand_sample(mode), 1'b0, '0);
        end
        push <= 1'b0;
        stim_done = 1;
    end

    initial
    begin
        int n;
        forever
        begin
            @(negedge clk);
            n = $urandom_range(0, 16);
            if (n != 0)
            begin
                pop <= 1'b0;
                repeat (n) @(negedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        median_word_t w;
        if (rst_n && pop && !empty)
        begin
            if (pending_medians.size() == 0)
            begin
                $error("result word with nothing expected");
                errors++;
            end
            else
            begin
                w = pending_medians.pop_front();
                if (median_times_two !== w.med2)
                begin
                    $error("median_times_two: expected %0d, actual %0d", w.med2,
                           median_times_two);
                    errors++;
                end
                if (sample_count !== w.count)
                begin
                    $error("sample_count: expected %0d, actual %0d", w.count, sample_count);
                    errors++;
                end
                if (dropped !== w.drop)
                begin
                    $error("dropped: expected %0d, actual %0d", w.drop, dropped);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (stim_done);
        while (pending_medians.size() != 0 && idle_cycles < LIMIT)
            @(posedge clk);
        if (idle_cycles < LIMIT)
            repeat (100) @(posedge clk);
        if (idle_cycles >= LIMIT)
            $display("** running_median_two_heaps: FAILED **");
        else if (errors == 0 && pending_medians.size() == 0)
            $display("** running_median_two_heaps: PASSED **");
        else
            $display("** running_median_two_heaps: FAILED **");
        $finish;
    end

    initial
    begin
        wait (idle_cycles >= LIMIT);
        $display("** running_median_two_heaps: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire

/* running_median_two_heaps.f */
src/rmth_pkg.sv
src/rmth_front.sv
src/rmth_heap.sv
src/rmth_back.sv
src/running_median_two_heaps.sv
src/rmth_checker.sv
tb/sv/running_median_two_heaps_tb.sv
